@@ hdl/arpp_pkg.sv @@
// Shared types, constants and frame helper functions for the ARP resolve / ping block.
// No dependencies; imported by every module under hdl.
package arpp_pkg;

    // Result kinds as seen on tx_kind
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ARP  = 2'd1,
        KIND_ICMP = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_OWN_IP    = 3'd0,
        REG_OWN_MAC   = 3'd1,
        REG_DEST_IP   = 3'd2,
        REG_NET_MASK  = 3'd3,
        REG_ROUTER_IP = 3'd4
    } reg_idx_t;

    localparam logic [7:0] ARP_OPCODE_REPLY = 8'h02;
    localparam logic [5:0] ARP_FRAME_LEN    = 6'd42;
    localparam logic [5:0] ICMP_HDR_LEN     = 6'd42;
    localparam logic [5:0] MIN_PAYLOAD_POS  = 6'd27;  // position of the 28th byte
    localparam int         MAX_ECHO_LEN     = 19;

    typedef struct packed {
        logic [31:0] own_ip;
        logic [47:0] own_mac;
        logic [31:0] dest_ip;
        logic [31:0] net_mask;
        logic [31:0] router_ip;
    } cfg_t;

    // One transmit request from the front part to the back part
    typedef struct packed {
        kind_t       kind;
        logic [31:0] tip;   // ARP target IP
        logic [47:0] mac;   // learned MAC after the step
    } cmd_t;

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
        logic [7:0] b;
        unique case (k)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            default: b = mac[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = ip[31:24];
            2'd1:    b = ip[23:16];
            2'd2:    b = ip[15:8];
            default: b = ip[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [7:0] echo_byte(input logic [1:0] p);
        logic [7:0] b;
        unique case (p)
            2'd0:    b = 8'hAB;
            2'd1:    b = 8'hCD;
            default: b = 8'hEF;
        endcase
        return b;
    endfunction

    // ICMP checksum: every word of the ICMP part is fixed for a given data length
    function automatic logic [15:0] icmp_csum(input int dlen);
        logic [31:0] sum;
        logic [1:0]  p;
        int          i;
        sum = 32'h0800 + 32'hACED + 32'h0001;
        p   = 2'd0;
        for (i = 0; i < dlen; i++) begin
            if (i[0] == 1'b0)
                sum = sum + {16'h0, echo_byte(p), 8'h00};
            else
                sum = sum + {24'h0, echo_byte(p)};
            p = (p == 2'd2) ? 2'd0 : p + 2'd1;
        end
        sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
        sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
        return ~sum[15:0];
    endfunction

endpackage

@@ hdl/arpp_front.sv @@
// Front part: accepts received payload bytes, captures ARP fields and decides
// what to send. Depends on arpp_pkg.
module arpp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    rx_byte,
    input  logic          rx_last,
    input  logic          rx_valid,
    output logic          rx_ready,
    input  arpp_pkg::cfg_t cfg,
    input  logic          fifo_full,
    output logic          push,
    output arpp_pkg::cmd_t push_cmd
);
    import arpp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_AWAIT = 3'b010,
        PH_DONE  = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  idx_reg, idx_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [47:0] smac_reg, smac_next;
    logic [31:0] tip_reg, tip_next;
    logic [47:0] learned_reg, learned_next;
    logic        accept;
    logic        local_dst;

    assign rx_ready  = !fifo_full;
    assign accept    = rx_valid && rx_ready;
    assign local_dst = ((cfg.dest_ip ^ cfg.own_ip) & cfg.net_mask) == 32'h0;

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        opcode_next  = opcode_reg;
        smac_next    = smac_reg;
        tip_next     = tip_reg;
        learned_next = learned_reg;
        push         = 1'b0;
        push_cmd     = '{kind: KIND_NONE, tip: 32'h0, mac: learned_reg};
        if (accept)
        begin
            // capture the fields of interest by position
            if (idx_reg == 6'd7)
                opcode_next = rx_byte;
            else if (idx_reg >= 6'd8 && idx_reg <= 6'd13)
                smac_next = {smac_reg[39:0], rx_byte};
            else if (idx_reg >= 6'd24 && idx_reg <= 6'd27)
                tip_next = {tip_reg[23:0], rx_byte};
            if (idx_reg != 6'd63)
                idx_next = idx_reg + 6'd1;
            if (rx_last)
            begin
                idx_next = 6'd0;
                if (idx_reg >= MIN_PAYLOAD_POS)
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                            push          = 1'b1;
                            push_cmd.kind = KIND_ARP;
                            push_cmd.tip  = local_dst ? cfg.dest_ip : cfg.router_ip;
                            phase_next    = PH_AWAIT;
                        end
                        PH_AWAIT:
                        begin
                            push = 1'b1;
                            if (opcode_next == ARP_OPCODE_REPLY && tip_next == cfg.own_ip)
                            begin
                                learned_next  = smac_next;
                                push_cmd.kind = KIND_ICMP;
                                push_cmd.mac  = smac_next;
                                phase_next    = PH_DONE;
                            end
                            else
                            begin
                                push_cmd.kind = KIND_ERR;
                            end
                        end
                        default:
                        begin
                            // done: count bytes, send nothing
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            idx_reg     <= 6'd0;
            opcode_reg  <= 8'h0;
            smac_reg    <= 48'h0;
            tip_reg     <= 32'h0;
            learned_reg <= 48'h0;
        end
        else
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            opcode_reg  <= opcode_next;
            smac_reg    <= smac_next;
            tip_reg     <= tip_next;
            learned_reg <= learned_next;
        end
    end

    // a request is only ever raised for an accepted byte
    a_push_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (accept && !fifo_full))
        else $error("front raised a request without room in the queue");

endmodule

@@ hdl/arpp_cmd_fifo.sv @@
// Short request queue between the front and back parts.
// Depends on arpp_pkg for the request type.
module arpp_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  arpp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output arpp_pkg::cmd_t pop_cmd,
    output logic           empty
);
    import arpp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

@@ hdl/arpp_back.sv @@
// Back part: takes requests from the queue and streams ARP request, ICMP echo
// or status results through an output register. Depends on arpp_pkg.
module arpp_back #(
    parameter int ECHO_DATA_LEN = 3
) (
    input  logic           clk,
    input  logic           rst_n,
    input  arpp_pkg::cfg_t cfg,
    input  logic           empty,
    input  arpp_pkg::cmd_t pop_cmd,
    output logic           pop,
    output logic           tx_valid,
    input  logic           tx_ready,
    output logic [7:0]     tx_byte,
    output logic           tx_last,
    output logic [1:0]     tx_kind,
    output logic [47:0]    resolved_mac
);
    import arpp_pkg::*;

    localparam int          DATA_LEN     = (ECHO_DATA_LEN > MAX_ECHO_LEN) ? MAX_ECHO_LEN
                                                                           : ECHO_DATA_LEN;
    localparam logic [5:0]  ICMP_LEN     = ICMP_HDR_LEN + 6'(DATA_LEN);
    localparam logic [15:0] TOTAL_LEN    = 16'(28 + DATA_LEN);
    localparam logic [18:0] IP_CSUM_BASE = 19'(32'h4500 + 32'hFACE + 32'hFF01 + 28 + DATA_LEN);
    localparam logic [15:0] ICMP_CSUM    = icmp_csum(DATA_LEN);
    localparam logic [2:0]  CS_FOLD_A    = 3'd4;
    localparam logic [2:0]  CS_FOLD_B    = 3'd5;
    localparam logic [2:0]  CS_DONE      = 3'd6;

    logic        busy_reg, busy_next;
    cmd_t        cmd_reg, cmd_next;
    logic [5:0]  idx_reg, idx_next;
    logic [1:0]  pat_reg, pat_next;
    logic [18:0] acc_reg, acc_next;
    logic [2:0]  cstep_reg, cstep_next;
    logic        ov_reg, ov_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        olast_reg, olast_next;
    kind_t       okind_reg, okind_next;
    logic [47:0] omac_reg, omac_next;

    logic [5:0]  frame_len;
    logic        hold_csum, emit, is_last;
    logic [7:0]  cur_byte;
    logic [15:0] ip_csum;
    logic [15:0] add_word;

    assign pop       = !busy_reg && !empty;
    assign ip_csum   = ~acc_reg[15:0];
    assign hold_csum = cmd_reg.kind == KIND_ICMP && idx_reg == 6'd24 && cstep_reg != CS_DONE;
    assign emit      = busy_reg && (!ov_reg || tx_ready) && !hold_csum;
    assign is_last   = idx_reg == frame_len - 6'd1;

    always_comb
    begin
        unique case (cmd_reg.kind)
            KIND_ARP:  frame_len = ARP_FRAME_LEN;
            KIND_ICMP: frame_len = ICMP_LEN;
            default:   frame_len = 6'd1;
        endcase
    end

    // frame byte at the current position
    always_comb
    begin
        cur_byte = 8'h00;
        unique case (cmd_reg.kind)
            KIND_ARP:
            begin
                priority if (idx_reg < 6'd6)
                    cur_byte = 8'hFF;
                else if (idx_reg < 6'd12)
                    cur_byte = mac_byte(cfg.own_mac, 3'(idx_reg - 6'd6));
                else if (idx_reg < 6'd22)
                begin
                    unique case (idx_reg)
                        6'd12:   cur_byte = 8'h08;
                        6'd13:   cur_byte = 8'h06;
                        6'd14:   cur_byte = 8'h00;
                        6'd15:   cur_byte = 8'h01;
                        6'd16:   cur_byte = 8'h08;
                        6'd17:   cur_byte = 8'h00;
                        6'd18:   cur_byte = 8'h06;
                        6'd19:   cur_byte = 8'h04;
                        6'd20:   cur_byte = 8'h00;
                        default: cur_byte = 8'h01;
                    endcase
                end
                else if (idx_reg < 6'd28)
                    cur_byte = mac_byte(cfg.own_mac, 3'(idx_reg - 6'd22));
                else if (idx_reg < 6'd32)
                    cur_byte = ip_byte(cfg.own_ip, 2'(idx_reg - 6'd28));
                else if (idx_reg < 6'd38)
                    cur_byte = 8'hFF;
                else
                    cur_byte = ip_byte(cmd_reg.tip, 2'(idx_reg - 6'd38));
            end
            KIND_ICMP:
            begin
                priority if (idx_reg < 6'd6)
                    cur_byte = mac_byte(cmd_reg.mac, 3'(idx_reg));
                else if (idx_reg < 6'd12)
                    cur_byte = mac_byte(cfg.own_mac, 3'(idx_reg - 6'd6));
                else if (idx_reg < 6'd26)
                begin
                    unique case (idx_reg)
                        6'd12:   cur_byte = 8'h08;
                        6'd13:   cur_byte = 8'h00;
                        6'd14:   cur_byte = 8'h45;
                        6'd15:   cur_byte = 8'h00;
                        6'd16:   cur_byte = TOTAL_LEN[15:8];
                        6'd17:   cur_byte = TOTAL_LEN[7:0];
                        6'd18:   cur_byte = 8'hFA;
                        6'd19:   cur_byte = 8'hCE;
                        6'd20:   cur_byte = 8'h00;
                        6'd21:   cur_byte = 8'h00;
                        6'd22:   cur_byte = 8'hFF;
                        6'd23:   cur_byte = 8'h01;
                        6'd24:   cur_byte = ip_csum[15:8];
                        default: cur_byte = ip_csum[7:0];
                    endcase
                end
                else if (idx_reg < 6'd30)
                    cur_byte = ip_byte(cfg.own_ip, 2'(idx_reg - 6'd26));
                else if (idx_reg < 6'd34)
                    cur_byte = ip_byte(cfg.dest_ip, 2'(idx_reg - 6'd30));
                else if (idx_reg < ICMP_HDR_LEN)
                begin
                    unique case (idx_reg)
                        6'd34:   cur_byte = 8'h08;
                        6'd35:   cur_byte = 8'h00;
                        6'd36:   cur_byte = ICMP_CSUM[15:8];
                        6'd37:   cur_byte = ICMP_CSUM[7:0];
                        6'd38:   cur_byte = 8'hAC;
                        6'd39:   cur_byte = 8'hED;
                        6'd40:   cur_byte = 8'h00;
                        default: cur_byte = 8'h01;
                    endcase
                end
                else
                    cur_byte = echo_byte(pat_reg);
            end
            default:
                cur_byte = 8'h00;
        endcase
    end

    // IP header checksum: one address word a cycle, then two end-around folds
    always_comb
    begin
        unique case (cstep_reg[1:0])
            2'd0:    add_word = cfg.own_ip[31:16];
            2'd1:    add_word = cfg.own_ip[15:0];
            2'd2:    add_word = cfg.dest_ip[31:16];
            default: add_word = cfg.dest_ip[15:0];
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        pat_next   = pat_reg;
        acc_next   = acc_reg;
        cstep_next = cstep_reg;
        ov_next    = ov_reg;
        obyte_next = obyte_reg;
        olast_next = olast_reg;
        okind_next = okind_reg;
        omac_next  = omac_reg;

        if (cstep_reg < CS_FOLD_A)
        begin
            acc_next   = acc_reg + {3'b000, add_word};
            cstep_next = cstep_reg + 3'd1;
        end
        else if (cstep_reg == CS_FOLD_A || cstep_reg == CS_FOLD_B)
        begin
            acc_next   = {3'b000, acc_reg[15:0]} + {16'h0, acc_reg[18:16]};
            cstep_next = cstep_reg + 3'd1;
        end

        if (pop)
        begin
            busy_next  = 1'b1;
            cmd_next   = pop_cmd;
            idx_next   = 6'd0;
            pat_next   = 2'd0;
            acc_next   = IP_CSUM_BASE;
            cstep_next = 3'd0;
        end

        if (emit)
        begin
            ov_next    = 1'b1;
            obyte_next = cur_byte;
            olast_next = is_last;
            okind_next = cmd_reg.kind;
            omac_next  = cmd_reg.mac;
            idx_next   = idx_reg + 6'd1;
            if (idx_reg >= ICMP_HDR_LEN)
                pat_next = (pat_reg == 2'd2) ? 2'd0 : pat_reg + 2'd1;
            if (is_last)
                busy_next = 1'b0;
        end
        else if (tx_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        pat_reg   <= pat_next;
        acc_reg   <= acc_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        okind_reg <= okind_next;
        omac_reg  <= omac_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            cstep_reg <= CS_DONE;
        end
        else
        begin
            busy_reg  <= busy_next;
            ov_reg    <= ov_next;
            cstep_reg <= cstep_next;
        end
    end

    assign tx_valid     = ov_reg;
    assign tx_byte      = obyte_reg;
    assign tx_last      = olast_reg;
    assign tx_kind      = okind_reg;
    assign resolved_mac = omac_reg;

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid && tx_kind == KIND_ERR) |-> (tx_last && tx_byte == 8'h00))
        else $error("status result must be a single zero byte");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (busy_reg && idx_reg == 6'd0 && cstep_reg == 3'd0))
        else $error("request taken without starting a frame");

    a_csum_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cmd_reg.kind == KIND_ICMP && idx_reg == 6'd25) |-> cstep_reg == CS_DONE)
        else $error("IP checksum sent before it settled");

endmodule

@@ hdl/arp_resolve_then_ping_sender.sv @@
// ARP resolve then ping: a request passes the queue and the back part's request and output registers.
// Results leave at one byte per cycle within a frame while tx_ready is high, one frame at a time:
// a 42-byte ARP request or a 42+ECHO_DATA_LEN byte ICMP frame (at most 19 data bytes), set by the
// back part's counter. Input bytes are taken one per cycle while the request queue has room.
// rst_n is asynchronous and active low: idle phase, empty queue, control and config registers at defaults.
module arp_resolve_then_ping_sender #(
    parameter int ECHO_DATA_LEN = 3,
    parameter int CMD_DEPTH     = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // received payload bytes
    input  logic [7:0]  rx_byte,
    input  logic        rx_last,
    input  logic        rx_valid,
    output logic        rx_ready,
    // transmitted frame bytes and status results
    output logic [7:0]  tx_byte,
    output logic        tx_last,
    output logic [1:0]  tx_kind,
    output logic [47:0] resolved_mac,
    output logic        tx_valid,
    input  logic        tx_ready,
    // configuration port, registers at 8-byte spacing
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import arpp_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        cfg_wr;
    logic [2:0]  reg_sel;

    logic        push, pop, fifo_full, fifo_empty;
    cmd_t        push_cmd, pop_cmd;

    // Configuration registers. The user must write them only while the block is idle;
    // the block does not enforce it. Both parts read them live without any shadow copies.
    assign pready  = 1'b1;
    assign reg_sel = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_OWN_IP:    cfg_next.own_ip    = pwdata[31:0];
                REG_OWN_MAC:   cfg_next.own_mac   = pwdata[47:0];
                REG_DEST_IP:   cfg_next.dest_ip   = pwdata[31:0];
                REG_NET_MASK:  cfg_next.net_mask  = pwdata[31:0];
                REG_ROUTER_IP: cfg_next.router_ip = pwdata[31:0];
                default:       cfg_next = cfg_reg;  // drop writes to unknown indexes
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_OWN_IP:    prdata = {32'h0, cfg_reg.own_ip};
            REG_OWN_MAC:   prdata = {16'h0, cfg_reg.own_mac};
            REG_DEST_IP:   prdata = {32'h0, cfg_reg.dest_ip};
            REG_NET_MASK:  prdata = {32'h0, cfg_reg.net_mask};
            REG_ROUTER_IP: prdata = {32'h0, cfg_reg.router_ip};
            default:       prdata = 64'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_ip    <= 32'hC0A8_010A;   // 192.168.1.10
            cfg_reg.own_mac   <= 48'h0;
            cfg_reg.dest_ip   <= 32'hACD9_01CE;   // 172.217.1.206
            cfg_reg.net_mask  <= 32'hFFFF_FF00;
            cfg_reg.router_ip <= 32'hC0A8_0101;   // 192.168.1.1
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: capture opcode, sender MAC and target IP; classify on the last byte
    // and raise one request per payload of at least 28 bytes, until the ICMP echo is requested.
    arpp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .rx_last  (rx_last),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .cfg      (cfg_reg),
        .fifo_full(fifo_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Queue: hold requests so reception carries on while a frame drains.
    arpp_cmd_fifo #(
        .DEPTH(CMD_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (fifo_full),
        .pop     (pop),
        .pop_cmd (pop_cmd),
        .empty   (fifo_empty)
    );

    // Back: advance through the frame a byte at a time, computing the IP header
    // checksum alongside the Ethernet header.
    arpp_back #(
        .ECHO_DATA_LEN(ECHO_DATA_LEN)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .empty       (fifo_empty),
        .pop_cmd     (pop_cmd),
        .pop         (pop),
        .tx_valid    (tx_valid),
        .tx_ready    (tx_ready),
        .tx_byte     (tx_byte),
        .tx_last     (tx_last),
        .tx_kind     (tx_kind),
        .resolved_mac(resolved_mac)
    );

endmodule
